/* rtl/core/afc_pkg.sv */
`default_nettype none

package afc_pkg;

  localparam int DEF_NUM_PLANES       = 6;
  localparam int DEF_FOOTPRINT_PLANES = 4;

  localparam int COEF_W = 32;
  localparam int EXT_W  = 31;
  // width that holds the plane distance and the corner spread around it
  localparam int SUM_W  = 68;
  localparam int D_SHIFT = 30;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BOX   = 2'd1,
    OP_FOOT  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]               operation;
    logic [2:0]               plane_index;
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
    logic signed [COEF_W-1:0] coef_d;
    logic signed [COEF_W-1:0] center_x;
    logic signed [COEF_W-1:0] center_y;
    logic signed [COEF_W-1:0] center_z;
    logic [EXT_W-1:0]         extent_x;
    logic [EXT_W-1:0]         extent_y;
    logic [EXT_W-1:0]         extent_z;
  } item_t;

  typedef struct packed {
    logic visible;
    logic fully_inside;
    logic is_test_result;
  } result_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
    logic signed [COEF_W-1:0] d;
  } plane_t;

  typedef struct packed {
    logic take_item;
    logic write_plane;
    logic start_test;
    logic issue;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic last_plane;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

/* rtl/core/afc_datapath.sv */
`default_nettype none

module afc_datapath
  import afc_pkg::*;
#(
  parameter int NUM_PLANES       = DEF_NUM_PLANES,
  parameter int FOOTPRINT_PLANES = DEF_FOOTPRINT_PLANES
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire item_t   item,
  input  wire cmd_t    cmd,
  output status_t      status,
  input  wire logic    result_stall,
  output logic         result_valid,
  output result_t      result
);

  localparam int PIDX_W   = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  localparam int FOOT_CNT = (FOOTPRINT_PLANES < NUM_PLANES) ? FOOTPRINT_PLANES : NUM_PLANES;
  localparam int BOX_LAST  = NUM_PLANES - 1;
  localparam int FOOT_LAST = FOOT_CNT - 1;
  localparam int PROD_W   = 2 * COEF_W;
  localparam int MAG_W    = COEF_W + EXT_W;
  localparam int SPREAD_W = MAG_W + 2;

  plane_t planes [NUM_PLANES];

  op_t                      op;
  logic signed [COEF_W-1:0] cen [3];
  logic [EXT_W-1:0]         ext [3];
  logic [PIDX_W-1:0]        cnt;

  // stage 1: products of one plane
  logic                     v1;
  logic signed [PROD_W-1:0] pc [3];
  logic [MAG_W-1:0]         pe [3];
  logic signed [COEF_W-1:0] d1;

  // stage 2: center distance and corner spread
  logic                     v2;
  logic signed [SUM_W-1:0]  base;
  logic [SPREAD_W-1:0]      spread;

  logic                     acc_vis;
  logic                     acc_in;

  plane_t                   sel;
  logic signed [COEF_W-1:0] coef [3];
  logic [COEF_W-1:0]        mag [3];
  logic signed [SUM_W-1:0]  far_dist;
  logic signed [SUM_W-1:0]  near_dist;
  logic                     idx_ok;
  logic                     is_test;

  assign sel     = planes[cnt];
  assign coef[0] = sel.a;
  assign coef[1] = sel.b;
  assign coef[2] = sel.c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = coef[i][COEF_W-1] ? (~coef[i] + 1'b1) : coef[i];
    end
  end

  assign idx_ok = {1'b0, item.plane_index} < 4'(NUM_PLANES);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        planes[i] <= '0;
      end
    end else if (cmd.write_plane && idx_ok) begin
      planes[item.plane_index[PIDX_W-1:0]] <= '{a: item.coef_a, b: item.coef_b,
                                                c: item.coef_c, d: item.coef_d};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      op     <= op_t'(item.operation);
      cen[0] <= item.center_x;
      cen[1] <= item.center_y;
      cen[2] <= item.center_z;
      ext[0] <= item.extent_x;
      // footprint: flat in y, square in x and z
      ext[1] <= (item.operation == OP_FOOT) ? '0 : item.extent_y;
      ext[2] <= (item.operation == OP_FOOT) ? item.extent_x : item.extent_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.start_test) begin
      cnt <= '0;
    end else if (cmd.issue) begin
      cnt <= cnt + 1'b1;
    end
  end

  assign status.last_plane = (op == OP_FOOT) ? (cnt == PIDX_W'(FOOT_LAST))
                                             : (cnt == PIDX_W'(BOX_LAST));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pc[i] <= PROD_W'(coef[i]) * PROD_W'(cen[i]);
      pe[i] <= MAG_W'(mag[i]) * MAG_W'(ext[i]);
    end
    d1 <= sel.d;
  end

  always_ff @(posedge clk) begin
    base   <= (SUM_W'(d1) <<< D_SHIFT) + SUM_W'(pc[0]) + SUM_W'(pc[1]) + SUM_W'(pc[2]);
    spread <= SPREAD_W'(pe[0]) + SPREAD_W'(pe[1]) + SPREAD_W'(pe[2]);
  end

  // farthest and nearest corners bound all eight corner distances
  assign far_dist  = base + $signed(SUM_W'(spread));
  assign near_dist = base - $signed(SUM_W'(spread));

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_vis <= 1'b0;
      acc_in  <= 1'b0;
    end else if (cmd.start_test) begin
      acc_vis <= 1'b1;
      acc_in  <= 1'b1;
    end else if (v2) begin
      acc_vis <= acc_vis & ~far_dist[SUM_W-1] & (far_dist != '0);
      acc_in  <= acc_in & ~near_dist[SUM_W-1];
    end
  end

  assign is_test = (op == OP_BOX) || (op == OP_FOOT);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.visible        <= is_test & acc_vis;
      result.fully_inside   <= (op == OP_BOX) & acc_in;
      result.is_test_result <= is_test;
    end
  end

  assign status.out_free = !result_valid || !result_stall;

endmodule

`default_nettype wire

/* rtl/core/afc_ctrl.sv */
`default_nettype none

module afc_ctrl
  import afc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  input  wire logic [1:0] item_op,
  output logic         item_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ISSUE  = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   drain_cnt, drain_cnt_next;

  assign item_stall = (state != ST_IDLE);

  always_comb begin
    state_next     = state;
    drain_cnt_next = drain_cnt;
    cmd            = '0;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.take_item = 1'b1;
          case (op_t'(item_op))
            OP_LOAD: begin
              cmd.write_plane = 1'b1;
              state_next      = ST_RESULT;
            end
            OP_BOX, OP_FOOT: begin
              cmd.start_test = 1'b1;
              state_next     = ST_ISSUE;
            end
            default: begin
              state_next = ST_RESULT;
            end
          endcase
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        if (status.last_plane) begin
          drain_cnt_next = 1'b0;
          state_next     = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait for the last plane to leave the pipeline
        drain_cnt_next = 1'b1;
        if (drain_cnt) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      drain_cnt <= 1'b0;
    end else begin
      state     <= state_next;
      drain_cnt <= drain_cnt_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/aabb_frustum_cull_unit.sv */
// Culls an axis-aligned box (center plus extent) against a table of NUM_PLANES
// planes. A load transaction writes one plane and is acknowledged with
// is_test_result 0; an index beyond the table writes nothing. A box test checks
// every plane, a footprint test only the first FOOTPRINT_PLANES with y extent 0
// and extent_x used for z. The plane pipeline evaluates one stored plane per
// cycle, and the input stays stalled until a test or load has been placed in
// the output register. The next transaction is taken while the previous result
// still waits in the output register. All planes read as zero after reset.
`default_nettype none

module aabb_frustum_cull_unit
  import afc_pkg::*;
#(
  parameter int NUM_PLANES       = DEF_NUM_PLANES,
  parameter int FOOTPRINT_PLANES = DEF_FOOTPRINT_PLANES
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_stall,
  input  wire item_t   item,
  output logic         result_valid,
  input  wire logic    result_stall,
  output result_t      result
);

  cmd_t    cmd;
  status_t status;

  afc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_op    (item.operation),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  afc_datapath #(
    .NUM_PLANES       (NUM_PLANES),
    .FOOTPRINT_PLANES (FOOTPRINT_PLANES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire
